/* src/upc_pkg.sv */
// ----------------------------------------------------------------------------
// upc_pkg
// Types and constants shared by the UDP port packet classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package upc_pkg;

  localparam int MAX_QUEUES = 64;

  localparam int MASK_W  = 64;
  localparam int PORT_W  = 16;
  localparam int COUNT_W = 7;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  localparam logic [PORT_W-1:0]  MATCH_PORT_RESET = 16'd53;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = 7'd127;

  // byte offsets within the frame
  localparam logic [COUNT_W-1:0] POS_ETYPE_HI = 7'd12;
  localparam logic [COUNT_W-1:0] POS_ETYPE_LO = 7'd13;
  localparam logic [COUNT_W-1:0] POS_V6_NH    = 7'd20;
  localparam logic [COUNT_W-1:0] POS_V4_PROTO = 7'd23;
  localparam logic [COUNT_W-1:0] POS_V4_DP_HI = 7'd36;
  localparam logic [COUNT_W-1:0] POS_V4_DP_LO = 7'd37;
  localparam logic [COUNT_W-1:0] POS_V6_DP_HI = 7'd56;
  localparam logic [COUNT_W-1:0] POS_V6_DP_LO = 7'd57;
  // last position of a frame that is just long enough
  localparam logic [COUNT_W-1:0] LAST_POS_V4  = 7'd41;
  localparam logic [COUNT_W-1:0] LAST_POS_V6  = 7'd61;

  // configuration register indexes
  localparam logic REG_QUEUE_MASK = 1'b0;
  localparam logic REG_MATCH_PORT = 1'b1;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       last_byte;
    logic [7:0] queue_index;
  } pkt_word_t;

  typedef struct packed {
    logic       redirect;
    logic [7:0] queue_out;
  } verdict_word_t;

endpackage

`default_nettype wire

/* src/udp_port_packet_classifier.sv */
// ----------------------------------------------------------------------------
// udp_port_packet_classifier
// Per-frame UDP destination port classifier for IPv4 and IPv6 over Ethernet.
// ----------------------------------------------------------------------------
// Usage:
//   pkt channel: one frame byte per word, with last_byte on the final byte
//   and the receive queue, sampled on the first byte of each frame.
//   verdict channel: one word per frame, sent after its last byte, with
//   redirect set when the frame is UDP to match_port on an enabled queue.
//   cfg port: cfg_we writes cfg_data into register cfg_index
//   (0 queue_enable_mask, 1 match_port); write only while idle.
// Timing:
//   one byte is accepted every cycle unless pkt_stall is high; the header
//   fields are captured in flat registers and the verdict is formed in the
//   same cycle as the last byte, then registered (result or skid register).
//   A two-entry output (result register plus skid register) lets one more
//   verdict be taken while the receiver stalls; pkt_stall rises only once
//   the skid register holds a verdict.
// Reset:
//   rst (synchronous) empties the output, clears the frame state, clears
//   queue_enable_mask and sets match_port to 53.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_port_packet_classifier
  import upc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                pkt_valid,
  output logic                     pkt_stall,
  input  wire pkt_word_t           pkt,
  output logic                     verdict_valid,
  input  wire logic                verdict_stall,
  output verdict_word_t            verdict,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [MASK_W-1:0]   cfg_data
);

  logic [MASK_W-1:0]  queue_enable_mask;
  logic [PORT_W-1:0]  match_port;

  logic [COUNT_W-1:0] byte_count;
  logic [15:0]        ether_type;
  logic [7:0]         l4_proto;
  logic [15:0]        udp_dest;
  logic [7:0]         frame_queue;

  logic [15:0]        ether_type_next;
  logic [7:0]         l4_proto_next;
  logic [15:0]        udp_dest_next;
  logic [7:0]         frame_queue_next;

  verdict_word_t      skid;
  logic               skid_valid;

  logic               accept;
  logic               res_valid;
  logic               out_free;
  logic               long_enough;
  logic               queue_ok;
  verdict_word_t      res;

  assign pkt_stall = skid_valid;
  assign accept    = pkt_valid && !pkt_stall;
  assign res_valid = accept && pkt.last_byte;
  assign out_free  = !verdict_valid || !verdict_stall;

  // capture header bytes at their fixed offsets
  always_comb begin
    ether_type_next  = ether_type;
    l4_proto_next    = l4_proto;
    udp_dest_next    = udp_dest;
    frame_queue_next = (byte_count == '0) ? pkt.queue_index : frame_queue;
    case (byte_count)
      POS_ETYPE_HI: ether_type_next[15:8] = pkt.pkt_byte;
      POS_ETYPE_LO: ether_type_next[7:0]  = pkt.pkt_byte;
      POS_V6_NH: begin
        if (ether_type == ETYPE_IPV6) l4_proto_next = pkt.pkt_byte;
      end
      POS_V4_PROTO: begin
        if (ether_type == ETYPE_IPV4) l4_proto_next = pkt.pkt_byte;
      end
      POS_V4_DP_HI: begin
        if (ether_type == ETYPE_IPV4) udp_dest_next[15:8] = pkt.pkt_byte;
      end
      POS_V4_DP_LO: begin
        if (ether_type == ETYPE_IPV4) udp_dest_next[7:0] = pkt.pkt_byte;
      end
      POS_V6_DP_HI: begin
        if (ether_type == ETYPE_IPV6) udp_dest_next[15:8] = pkt.pkt_byte;
      end
      POS_V6_DP_LO: begin
        if (ether_type == ETYPE_IPV6) udp_dest_next[7:0] = pkt.pkt_byte;
      end
      default: ;
    endcase
  end

  always_comb begin
    long_enough = ((ether_type_next == ETYPE_IPV4) && (byte_count >= LAST_POS_V4)) ||
                  ((ether_type_next == ETYPE_IPV6) && (byte_count >= LAST_POS_V6));
    queue_ok    = (frame_queue_next < 8'(MAX_QUEUES)) &&
                  queue_enable_mask[frame_queue_next[5:0]];
    res.redirect  = long_enough && (l4_proto_next == PROTO_UDP) &&
                    (udp_dest_next == match_port) && queue_ok;
    res.queue_out = frame_queue_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_enable_mask <= '0;
      match_port        <= MATCH_PORT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_QUEUE_MASK: queue_enable_mask <= cfg_data;
        REG_MATCH_PORT: match_port        <= cfg_data[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      ether_type  <= '0;
      l4_proto    <= '0;
      udp_dest    <= '0;
      frame_queue <= '0;
    end else if (accept) begin
      if (pkt.last_byte) begin
        byte_count  <= '0;
        ether_type  <= '0;
        l4_proto    <= '0;
        udp_dest    <= '0;
        frame_queue <= '0;
      end else begin
        if (byte_count != COUNT_MAX) byte_count <= byte_count + 1'b1;
        ether_type  <= ether_type_next;
        l4_proto    <= l4_proto_next;
        udp_dest    <= udp_dest_next;
        frame_queue <= frame_queue_next;
      end
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        verdict       <= skid;
        verdict_valid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        verdict       <= res;
        verdict_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid       <= res;
      skid_valid <= 1'b1;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> verdict_valid)
    else $error("skid entry held with empty result register");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> (byte_count == '0) && (ether_type == '0))
    else $error("frame state not cleared after last byte");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && verdict_valid && verdict_stall) |=> skid_valid)
    else $error("verdict lost while receiver stalled");

  a_redirect_queue_range: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && verdict.redirect) |-> (verdict.queue_out < 8'(MAX_QUEUES)))
    else $error("redirect for out-of-range queue");

  a_verdict_from_result: assert property (@(posedge clk) disable iff (rst)
    (!verdict_valid && !res_valid) |=> !verdict_valid)
    else $error("verdict without a last byte");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives Ethernet frames byte by byte into udp_port_packet_classifier and
// checks every verdict against a cycle-free model of the header parser.
// Directed frames cover the length limits, both IP versions, foreign
// ethertypes, out-of-range queues and counter saturation. Random phases then
// mix well-formed UDP frames with broken and noise frames under varying
// sender and receiver stalls and several register settings.
// ----------------------------------------------------------------------------

module testbench;
  import upc_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int HOLD_CYCLES   = 300;

  class verdict_scoreboard;
    logic [MASK_W-1:0]  queue_mask;
    logic [PORT_W-1:0]  match_port;
    logic [COUNT_W-1:0] byte_pos;
    logic [15:0]        ether_type;
    logic [7:0]         l4_proto;
    logic [15:0]        udp_dest;
    logic [7:0]         frame_queue;
    verdict_word_t      expected_q[$];
    int                 errors;

    function new();
      queue_mask = '0;
      match_port = MATCH_PORT_RESET;
      errors     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos    = '0;
      ether_type  = '0;
      l4_proto    = '0;
      udp_dest    = '0;
      frame_queue = '0;
    endfunction

    function void set_reg(logic idx, logic [MASK_W-1:0] data);
      if (idx == REG_QUEUE_MASK) begin
        queue_mask = data;
      end else begin
        match_port = data[PORT_W-1:0];
      end
    endfunction

    function void note_word(pkt_word_t w);
      logic          long_enough;
      logic          hit;
      verdict_word_t v;
      if (byte_pos == '0) begin
        frame_queue = w.queue_index;
      end
      case (byte_pos)
        POS_ETYPE_HI: ether_type[15:8] = w.pkt_byte;
        POS_ETYPE_LO: ether_type[7:0] = w.pkt_byte;
        POS_V6_NH:    if (ether_type == ETYPE_IPV6) l4_proto = w.pkt_byte;
        POS_V4_PROTO: if (ether_type == ETYPE_IPV4) l4_proto = w.pkt_byte;
        POS_V4_DP_HI: if (ether_type == ETYPE_IPV4) udp_dest[15:8] = w.pkt_byte;
        POS_V4_DP_LO: if (ether_type == ETYPE_IPV4) udp_dest[7:0] = w.pkt_byte;
        POS_V6_DP_HI: if (ether_type == ETYPE_IPV6) udp_dest[15:8] = w.pkt_byte;
        POS_V6_DP_LO: if (ether_type == ETYPE_IPV6) udp_dest[7:0] = w.pkt_byte;
        default: ;
      endcase
      if (!w.last_byte) begin
        if (byte_pos != COUNT_MAX) byte_pos = byte_pos + 1'b1;
        return;
      end
      long_enough = (ether_type == ETYPE_IPV4 && byte_pos >= LAST_POS_V4) ||
                    (ether_type == ETYPE_IPV6 && byte_pos >= LAST_POS_V6);
      hit = long_enough && l4_proto == PROTO_UDP && udp_dest == match_port &&
            frame_queue < MAX_QUEUES && queue_mask[frame_queue[5:0]];
      v.redirect  = hit;
      v.queue_out = frame_queue;
      expected_q.push_back(v);
      clear_frame();
    endfunction

    function void check_verdict(verdict_word_t got);
      verdict_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected verdict: redirect=%0d queue=%0d", got.redirect, got.queue_out);
        return;
      end
      want = expected_q.pop_front();
      if (got.redirect !== want.redirect || got.queue_out !== want.queue_out) begin
        errors++;
        if (errors <= 10)
          $display("verdict mismatch: expected redirect=%0d queue=%0d, got redirect=%0d queue=%0d",
                   want.redirect, want.queue_out, got.redirect, got.queue_out);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               pkt_valid;
  logic               pkt_stall;
  pkt_word_t          pkt;
  logic               verdict_valid;
  logic               verdict_stall;
  verdict_word_t      verdict;
  logic               cfg_we;
  logic               cfg_index;
  logic [MASK_W-1:0]  cfg_data;

  verdict_scoreboard sb = new();

  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  int          cycle_count;
  int          bytes_sent;
  int          frames_sent;
  logic [7:0]  frame_bytes[$];

  udp_port_packet_classifier dut (
    .clk           (clk),
    .rst           (rst),
    .pkt_valid     (pkt_valid),
    .pkt_stall     (pkt_stall),
    .pkt           (pkt),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict       (verdict),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** udp_port_packet_classifier: FAILED **");
    $finish;
  end

  // verdict receiver, with random stalls and long hold-offs
  initial begin
    verdict_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && verdict_valid && !verdict_stall) sb.check_verdict(verdict);
      if (hold_left > 0) begin
        verdict_stall <= 1'b1;
        hold_left--;
      end else begin
        verdict_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_word(pkt_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_valid <= 1'b0;
      @(posedge clk);
    end
    pkt_valid <= 1'b1;
    pkt       <= w;
    @(posedge clk);
    while (pkt_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic send_frame(logic [7:0] q);
    pkt_word_t w;
    int        n;
    n = frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      w.pkt_byte    = frame_bytes[i];
      w.last_byte   = (i == n - 1);
      // queue index only matters on the first byte
      w.queue_index = (i == 0) ? q : 8'($urandom_range(255));
      send_word(w);
    end
    bytes_sent  += n;
    frames_sent += 1;
  endtask

  function automatic void put_byte(int pos, logic [7:0] val);
    if (pos < frame_bytes.size()) frame_bytes[pos] = val;
  endfunction

  function automatic void fill_frame(logic [15:0] etype, logic [7:0] proto,
                                     logic [15:0] dport, int len);
    frame_bytes.delete();
    for (int i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(255)));
    put_byte(POS_ETYPE_HI, etype[15:8]);
    put_byte(POS_ETYPE_LO, etype[7:0]);
    if (etype == ETYPE_IPV6) begin
      put_byte(POS_V6_NH, proto);
      put_byte(POS_V6_DP_HI, dport[15:8]);
      put_byte(POS_V6_DP_LO, dport[7:0]);
    end else begin
      put_byte(POS_V4_PROTO, proto);
      put_byte(POS_V4_DP_HI, dport[15:8]);
      put_byte(POS_V4_DP_LO, dport[7:0]);
    end
  endfunction

  task automatic send_header_frame(logic [15:0] etype, logic [7:0] proto,
                                   logic [15:0] dport, int len, logic [7:0] q);
    fill_frame(etype, proto, dport, len);
    send_frame(q);
  endtask

  task automatic write_reg(logic idx, logic [MASK_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // wait for every verdict, then let the pipeline go quiet
  task automatic settle();
    pkt_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int pick_len(int min_len);
    if ($urandom_range(99) < 5) return $urandom_range(160, 128);
    return $urandom_range(min_len + 30, min_len);
  endfunction

  task automatic random_frame();
    int          r;
    logic [15:0] port;
    logic [7:0]  q;
    r = $urandom_range(99);
    case ($urandom_range(9))
      0, 1:    port = 16'($urandom);
      2:       port = sb.match_port ^ (16'h1 << $urandom_range(15));
      default: port = sb.match_port;
    endcase
    q = ($urandom_range(99) < 85) ? 8'($urandom_range(63)) : 8'($urandom_range(255, 64));
    if (r < 40) begin
      send_header_frame(ETYPE_IPV4, PROTO_UDP, port, pick_len(int'(LAST_POS_V4) + 1), q);
    end else if (r < 70) begin
      send_header_frame(ETYPE_IPV6, PROTO_UDP, port, pick_len(int'(LAST_POS_V6) + 1), q);
    end else if (r < 75) begin
      // truncated just around the minimum length
      send_header_frame(ETYPE_IPV4, PROTO_UDP, port, $urandom_range(42, 34), q);
    end else if (r < 80) begin
      send_header_frame(ETYPE_IPV6, PROTO_UDP, port, $urandom_range(62, 54), q);
    end else if (r < 85) begin
      send_header_frame(($urandom_range(1) != 0) ? ETYPE_IPV4 : ETYPE_IPV6,
                        8'($urandom_range(255)), port, pick_len(62), q);
    end else if (r < 90) begin
      send_header_frame(16'($urandom), PROTO_UDP, port, pick_len(62), q);
    end else begin
      send_header_frame(16'($urandom), 8'($urandom), 16'($urandom), $urandom_range(30, 1), q);
    end
  endtask

  task automatic run_phase(int snd_pct, int rcv_pct, logic [MASK_W-1:0] mask,
                           logic [15:0] port, bit pressure);
    int start_bytes;
    int start_frames;
    settle();
    write_reg(REG_QUEUE_MASK, mask);
    // upper bits of the port write are don't-care
    write_reg(REG_MATCH_PORT, {32'($urandom), 16'($urandom), port});
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start_bytes   = bytes_sent;
    start_frames  = frames_sent;
    while (bytes_sent - start_bytes < 120 || frames_sent - start_frames < 3) begin
      random_frame();
      if (pressure && frames_sent - start_frames == 2) begin
        // receiver holds off while short frames pile up behind it
        hold_left = HOLD_CYCLES;
        repeat (25) send_header_frame(16'($urandom), 8'($urandom), 16'($urandom),
                                      $urandom_range(4, 1), 8'($urandom));
        settle();
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    pkt_valid     = 1'b0;
    pkt           = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_QUEUE_MASK;
    cfg_data      = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    bytes_sent    = 0;
    frames_sent   = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: mask clear, so a matching frame is not redirected
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'd53, 42, 8'd0);
    settle();
    write_reg(REG_QUEUE_MASK, '1);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'd53, 42, 8'd0);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'd53, 41, 8'd5);
    send_header_frame(ETYPE_IPV6, PROTO_UDP, 16'd53, 62, 8'd63);
    send_header_frame(ETYPE_IPV6, PROTO_UDP, 16'd53, 61, 8'd63);
    send_header_frame(ETYPE_IPV4, 8'd6, 16'd53, 42, 8'd1);
    send_header_frame(16'h0806, PROTO_UDP, 16'd53, 42, 8'd2);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'd53, 42, 8'd64);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'd53, 42, 8'd255);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'd54, 42, 8'd3);
    // counter saturates on long frames
    send_header_frame(ETYPE_IPV6, PROTO_UDP, 16'd53, 150, 8'd7);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'd53, 1, 8'd9);
    fill_frame(ETYPE_IPV4, PROTO_UDP, 16'd53, 42);
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    send_frame(8'h00);
    foreach (frame_bytes[i]) frame_bytes[i] = 8'hFF;
    send_frame(8'hFF);
    settle();
    write_reg(REG_MATCH_PORT, 64'h0);
    write_reg(REG_QUEUE_MASK, 64'h1);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'h0000, 42, 8'd0);
    send_header_frame(ETYPE_IPV4, PROTO_UDP, 16'h0000, 42, 8'd1);
    send_header_frame(ETYPE_IPV6, PROTO_UDP, 16'h0000, 62, 8'd0);

    run_phase(26, 76, {32'($urandom), 32'($urandom)}, 16'($urandom), 1'b0);
    run_phase(76, 26, '1, 16'hFFFF, 1'b0);
    run_phase(0, 0, {32'($urandom), 32'($urandom)}, 16'h0000, 1'b1);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** udp_port_packet_classifier: PASSED **");
    end else begin
      $display("** udp_port_packet_classifier: FAILED **");
    end
    $finish;
  end

endmodule

/* udp_port_packet_classifier.f */
src/upc_pkg.sv
src/udp_port_packet_classifier.sv
bench/testbench.sv
